@@ rtl/tcc_pkg.sv @@
// Shared types, codes and default parameters of the throttle command conditioner.
package tcc_pkg;

    // Default build parameters
    localparam int TIMER_RATE_DEF     = 10000;
    localparam int PULSES_PER_REV_DEF = 12;
    localparam int SMOOTH_SHIFT_DEF   = 3;

    // Mode register codes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_ANALOG = 2'd1;
    localparam logic [1:0] MODE_PEDAL  = 2'd2;

    // Operation codes of an input item
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_EDGE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_B0    = 3'd1;
    localparam logic [2:0] REG_A1    = 3'd2;
    localparam logic [2:0] REG_A2    = 3'd3;
    localparam logic [2:0] REG_MIN   = 3'd4;
    localparam logic [2:0] REG_GAIN  = 3'd5;
    localparam logic [2:0] REG_HYST  = 3'd6;
    localparam logic [2:0] REG_RISE  = 3'd7;

    localparam logic [15:0] RISE_STEP_RESET = 16'd32768;
    localparam logic [15:0] SPEED_MAX       = 16'hFFFF;

    // Configuration register file contents
    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [15:0] coef_b0;
        logic signed [15:0] coef_a1;
        logic signed [15:0] coef_a2;
        logic        [15:0] min_level;
        logic        [15:0] scale_gain;
        logic        [15:0] hyst_level;
        logic        [15:0] rise_step;
    } cfg_t;

endpackage

@@ rtl/tcc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module tcc_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    // One restoring step
    always_comb
    begin
        shifted    = {rem_reg, quot_reg[NUM_W-1]};
        trial      = shifted - {1'b0, den_reg};
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_next  = trial[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ rtl/tcc_core.sv @@
// Sequencer, shared multiplier and state of the throttle command conditioner.
module tcc_core #(
    parameter int TIMER_RATE     = tcc_pkg::TIMER_RATE_DEF,
    parameter int PULSES_PER_REV = tcc_pkg::PULSES_PER_REV_DEF,
    parameter int SMOOTH_SHIFT   = tcc_pkg::SMOOTH_SHIFT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tcc_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    op,
    input  logic [11:0]   adc_sample,
    input  logic [15:0]   pulse_period,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [15:0]   command,
    output logic          engaged
);
    localparam int NUM_W   = $clog2(TIMER_RATE * 16 + 1);
    localparam int DEN_W   = 16 + $clog2(PULSES_PER_REV + 1);
    localparam logic [NUM_W-1:0] SPEED_NUM = NUM_W'(TIMER_RATE * 16);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_F0     = 13'b0000000000010,
        ST_F1     = 13'b0000000000100,
        ST_F2     = 13'b0000000001000,
        ST_F3     = 13'b0000000010000,
        ST_F4     = 13'b0000000100000,
        ST_L0     = 13'b0000001000000,
        ST_L1     = 13'b0000010000000,
        ST_DEN    = 13'b0000100000000,
        ST_DIV    = 13'b0001000000000,
        ST_DWAIT  = 13'b0010000000000,
        ST_SMOOTH = 13'b0100000000000,
        ST_DONE   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Persistent state
    logic [11:0]        x1_reg, x2_reg;
    logic signed [31:0] y1_reg, y2_reg;
    logic [15:0]        cmd_reg, cmd_next;
    logic [15:0]        last_reg, last_next;
    logic               on_reg, on_next;
    logic [27:0]        speed_s_reg;

    // Working registers
    logic [11:0]        x_reg;
    logic [15:0]        count_reg;
    logic               analog_reg;
    logic signed [51:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic signed [32:0] lvl_reg;
    logic [15:0]        speed_reg;

    // Result register
    logic               out_valid_reg;
    logic [15:0]        out_cmd_reg;
    logic               out_eng_reg;

    // Shared multiplier operands
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;

    // Divider
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;

    // Combinational helpers
    logic [14:0]        xs;
    logic signed [37:0] acc_sh;
    logic signed [31:0] y_sat;
    logic [16:0]        clip_val;
    logic [16:0]        hyst_val;
    logic               hyst_on;
    logic [15:0]        slew_src;
    logic [16:0]        slew_lim;
    logic [15:0]        slew_out;
    logic [31:0]        quot_ext;
    logic signed [28:0] s_diff;
    logic signed [28:0] s_step;
    logic [27:0]        s_new;
    logic               load_out;

    tcc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (SPEED_NUM),
        .den   (prod_reg[DEN_W-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Filter input sum and output saturation
    always_comb
    begin
        xs     = 15'(x_reg) + {2'b0, x1_reg, 1'b0} + 15'(x2_reg);
        acc_sh = acc_reg[51:14];
        if (acc_sh > 38'sh007FFFFFFF)
        begin
            y_sat = 32'sh7FFFFFFF;
        end
        else if (acc_sh < -38'sh0080000000)
        begin
            y_sat = -32'sh80000000;
        end
        else
        begin
            y_sat = acc_sh[31:0];
        end
    end

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_F0:
            begin
                mul_a = 34'({xs, 4'b0});
                mul_b = 18'(cfg.coef_b0);
            end
            ST_F1:
            begin
                mul_a = 34'(y1_reg);
                mul_b = 18'(cfg.coef_a1);
            end
            ST_F2:
            begin
                mul_a = 34'(y2_reg);
                mul_b = 18'(cfg.coef_a2);
            end
            ST_L0:
            begin
                mul_a = 34'(lvl_reg) - $signed({18'b0, cfg.min_level});
                mul_b = $signed({2'b0, cfg.scale_gain});
            end
            ST_DEN:
            begin
                mul_a = $signed({18'b0, count_reg});
                mul_b = 18'(PULSES_PER_REV);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Clip the scaled level to 0..100%, then hysteresis
    always_comb
    begin
        if (prod_reg[51])
        begin
            clip_val = '0;
        end
        else if (prod_reg[51:1] > 51'd32768)
        begin
            clip_val = 17'd32768;
        end
        else
        begin
            clip_val = prod_reg[17:1];
        end
        hyst_val = clip_val;
        hyst_on  = on_reg;
        if (on_reg)
        begin
            if (clip_val <= {1'b0, cfg.hyst_level})
            begin
                hyst_val = '0;
                hyst_on  = 1'b0;
            end
        end
        else
        begin
            if (clip_val >= {cfg.hyst_level, 1'b0})
            begin
                hyst_on = 1'b1;
            end
            else
            begin
                hyst_val = '0;
            end
        end
    end

    // Upward slew limit
    always_comb
    begin
        slew_src = (state_reg == ST_L1) ? hyst_val[15:0] : cmd_reg;
        slew_lim = {1'b0, last_reg} + {1'b0, cfg.rise_step};
        if ({1'b0, slew_src} > slew_lim)
        begin
            slew_out = slew_lim[15:0];
        end
        else
        begin
            slew_out = slew_src;
        end
    end

    // Speed smoothing
    always_comb
    begin
        quot_ext = 32'(div_quot);
        s_diff   = $signed({1'b0, speed_reg, 12'b0}) - $signed({1'b0, speed_s_reg});
        s_step   = s_diff >>> SMOOTH_SHIFT;
        s_new    = 28'($signed({1'b0, speed_s_reg}) + s_step);
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        last_next  = last_reg;
        on_next    = on_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DONE;
                    if (op == tcc_pkg::OP_TICK)
                    begin
                        if (cfg.mode == tcc_pkg::MODE_ANALOG)
                        begin
                            state_next = ST_F0;
                        end
                        else if (cfg.mode == tcc_pkg::MODE_PEDAL)
                        begin
                            cmd_next  = slew_out;
                            last_next = slew_out;
                        end
                        else
                        begin
                            cmd_next = '0;
                        end
                    end
                    else if (op == tcc_pkg::OP_EDGE)
                    begin
                        if (cfg.mode == tcc_pkg::MODE_PEDAL)
                        begin
                            state_next = ST_DEN;
                        end
                    end
                    else if (op == tcc_pkg::OP_TIMEOUT)
                    begin
                        if (cfg.mode == tcc_pkg::MODE_PEDAL)
                        begin
                            cmd_next = '0;
                        end
                    end
                end
            end
            ST_F0:
            begin
                state_next = ST_F1;
            end
            ST_F1:
            begin
                state_next = ST_F2;
            end
            ST_F2:
            begin
                state_next = ST_F3;
            end
            ST_F3:
            begin
                state_next = ST_F4;
            end
            ST_F4:
            begin
                state_next = ST_L0;
            end
            ST_L0:
            begin
                state_next = ST_L1;
            end
            ST_L1:
            begin
                if (analog_reg)
                begin
                    on_next   = hyst_on;
                    cmd_next  = slew_out;
                    last_next = slew_out;
                end
                else
                begin
                    cmd_next = clip_val[15:0];
                end
                state_next = ST_DONE;
            end
            ST_DEN:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_SMOOTH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DWAIT;
                end
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH:
            begin
                state_next = ST_L0;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
            cmd_reg       <= '0;
            last_reg      <= '0;
            on_reg        <= 1'b0;
            speed_s_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            last_reg  <= last_next;
            on_reg    <= on_next;
            if (state_reg == ST_F4)
            begin
                x2_reg <= x1_reg;
                x1_reg <= x_reg;
                y2_reg <= y1_reg;
                y1_reg <= y_sat;
            end
            if ((state_reg == ST_IDLE) && in_valid && (op == tcc_pkg::OP_TIMEOUT)
                && (cfg.mode == tcc_pkg::MODE_PEDAL))
            begin
                speed_s_reg <= '0;
            end
            else if (state_reg == ST_SMOOTH)
            begin
                speed_s_reg <= s_new;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            x_reg      <= adc_sample;
            count_reg  <= pulse_period;
            analog_reg <= (op == tcc_pkg::OP_TICK);
        end
        case (state_reg)
            ST_F1:
            begin
                acc_reg <= prod_reg;
            end
            ST_F2, ST_F3:
            begin
                acc_reg <= acc_reg - prod_reg;
            end
            ST_F4:
            begin
                lvl_reg <= 33'(y_sat);
            end
            ST_SMOOTH:
            begin
                lvl_reg <= $signed({17'b0, s_new[27:12]});
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_DIV)
        begin
            speed_reg <= tcc_pkg::SPEED_MAX;
        end
        else if ((state_reg == ST_DWAIT) && div_done)
        begin
            speed_reg <= (quot_ext >= 32'(tcc_pkg::SPEED_MAX)) ? tcc_pkg::SPEED_MAX
                                                                : quot_ext[15:0];
        end
        if (load_out)
        begin
            out_cmd_reg <= cmd_reg;
            out_eng_reg <= on_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign command   = out_cmd_reg;
    assign engaged   = out_eng_reg;

endmodule

@@ rtl/throttle_command_conditioner_top.sv @@
// Top level of the throttle command conditioner: configuration registers and core.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_ready    op, adc_sample, pulse_period
//  out      output     out_valid/out_ready  command, engaged
//  cfg      input      cfg_we (no wait)     cfg_index, cfg_data
//
// An analog tick runs through the shared multiplier in ST_F0 to ST_F4, ST_L0 and
// ST_L1; a pedal edge runs through ST_DEN, ST_DIV, the one-bit-a-cycle divider
// (ST_DWAIT), ST_SMOOTH, ST_L0 and ST_L1, and a zero count skips the divider.
// Other items go straight to ST_DONE.
// Reset clears control, persistent and configuration state, not data registers;
// rise_step resets to 100%. A waiting result stalls the core only in ST_DONE, so
// one item may be accepted and worked on while the previous transfer is pending.
module throttle_command_conditioner_top #(
    parameter int TIMER_RATE     = tcc_pkg::TIMER_RATE_DEF,
    parameter int PULSES_PER_REV = tcc_pkg::PULSES_PER_REV_DEF,
    parameter int SMOOTH_SHIFT   = tcc_pkg::SMOOTH_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [11:0] adc_sample,
    input  logic [15:0] pulse_period,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] command,
    output logic        engaged
);
    tcc_pkg::cfg_t cfg_reg;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= tcc_pkg::MODE_NONE;
            cfg_reg.coef_b0    <= '0;
            cfg_reg.coef_a1    <= '0;
            cfg_reg.coef_a2    <= '0;
            cfg_reg.min_level  <= '0;
            cfg_reg.scale_gain <= '0;
            cfg_reg.hyst_level <= '0;
            cfg_reg.rise_step  <= tcc_pkg::RISE_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcc_pkg::REG_MODE: cfg_reg.mode       <= cfg_data[1:0];
                tcc_pkg::REG_B0:   cfg_reg.coef_b0    <= $signed(cfg_data);
                tcc_pkg::REG_A1:   cfg_reg.coef_a1    <= $signed(cfg_data);
                tcc_pkg::REG_A2:   cfg_reg.coef_a2    <= $signed(cfg_data);
                tcc_pkg::REG_MIN:  cfg_reg.min_level  <= cfg_data;
                tcc_pkg::REG_GAIN: cfg_reg.scale_gain <= cfg_data;
                tcc_pkg::REG_HYST: cfg_reg.hyst_level <= cfg_data;
                tcc_pkg::REG_RISE: cfg_reg.rise_step  <= cfg_data;
                default:           cfg_reg.mode       <= cfg_reg.mode;
            endcase
        end
    end

    tcc_core #(
        .TIMER_RATE     (TIMER_RATE),
        .PULSES_PER_REV (PULSES_PER_REV),
        .SMOOTH_SHIFT   (SMOOTH_SHIFT)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .adc_sample   (adc_sample),
        .pulse_period (pulse_period),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command      (command),
        .engaged      (engaged)
    );

endmodule
